### rtl/drect_pkg.sv
// Shared types, codes and a helper function for the rectangle outline overlay.
`timescale 1ns / 1ps
package drect_pkg;

  localparam int MAX_RECTS  = 16;
  localparam int RECT_IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int RECT_CNT_W = $clog2(MAX_RECTS + 1);

  localparam logic [15:0] OUTLINE_COLOR_RESET = 16'hF81F;

  // Input command codes
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_PIXEL  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_COLOR  = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } rect_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TEST,
    ST_DONE
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_record;
    logic take_clear;
    logic take_pixel;
    logic test;
    logic advance;
    logic load_out;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_needed;
    logic hit;
    logic last;
    logic out_busy;
  } dp_status_t;

  // True when the pixel lies on the border of a non-empty rectangle.
  function automatic logic rect_border_hit(rect_t r, logic [14:0] px, logic [14:0] py);
    logic signed [17:0] sx;
    logic signed [17:0] sy;
    logic signed [17:0] right;
    logic signed [17:0] bottom;
    logic signed [17:0] qx;
    logic signed [17:0] qy;
    logic               size_ok;
    logic               in_box;
    sx      = $signed({{2{r.x[15]}}, r.x});
    sy      = $signed({{2{r.y[15]}}, r.y});
    right   = sx + $signed({{2{r.w[15]}}, r.w}) - 18'sd1;
    bottom  = sy + $signed({{2{r.h[15]}}, r.h}) - 18'sd1;
    qx      = $signed({3'b000, px});
    qy      = $signed({3'b000, py});
    size_ok = !r.w[15] && (r.w != 16'sd0) && !r.h[15] && (r.h != 16'sd0);
    in_box  = (qx >= sx) && (qx <= right) && (qy >= sy) && (qy <= bottom);
    return size_ok && in_box &&
           ((qy == sy) || (qy == bottom) || (qx == sx) || (qx == right));
  endfunction

endpackage

### rtl/dirty_rect_outline_overlay.sv
// Top level of the rectangle outline overlay: controller plus datapath.
`timescale 1ns / 1ps
// Sequence: a record result goes through the done state into the output register; a pixel
//   first scans the table, a fetch and a test state per entry, stopping at the first hit or last entry.
// Throughput: one item at a time; the next is accepted once the result sits in the
//   output register, and a clear gives no result. The scan loop (one registered table
//   read plus one border test per entry) sets the pixel rate.
// Reset (synchronous, active high): table empty, overlay disabled, color 0xF81F.
module dirty_rect_outline_overlay (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  // Input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  logic signed [15:0]  rect_x,
  input  logic signed [15:0]  rect_y,
  input  logic signed [15:0]  rect_width,
  input  logic signed [15:0]  rect_height,
  input  logic [14:0]         pixel_x,
  input  logic [14:0]         pixel_y,
  input  logic [15:0]         pixel_value,
  // Output channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         pixel_out,
  output logic                on_outline,
  output logic                table_full
);

  drect_pkg::dp_cmd_t    cmd;
  drect_pkg::dp_status_t status;

  // The controller owns the input handshake and steps through each transaction;
  // it hands the finished result to the output register and returns to idle.
  drect_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the table and the output stage; the output
  // register decouples the result from the next accepted transaction.
  drect_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_value (pixel_value),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_out   (pixel_out),
    .on_outline  (on_outline),
    .table_full  (table_full)
  );

endmodule

### rtl/drect_ctrl.sv
// Controller state machine: sequences record, clear, table scan and result hand-off.
`timescale 1ns / 1ps
module drect_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  drect_pkg::dp_status_t status,
  output drect_pkg::dp_cmd_t    cmd
);

  drect_pkg::ctrl_state_t state;
  drect_pkg::ctrl_state_t state_next;

  logic take;

  assign take = in_valid && (state == drect_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drect_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      drect_pkg::ST_IDLE: begin
        if (take) begin
          case (command)
            drect_pkg::CMD_RECORD: state_next = drect_pkg::ST_DONE;
            drect_pkg::CMD_PIXEL: begin
              state_next = status.scan_needed ? drect_pkg::ST_FETCH : drect_pkg::ST_DONE;
            end
            default: state_next = drect_pkg::ST_IDLE;
          endcase
        end
      end
      drect_pkg::ST_FETCH: state_next = drect_pkg::ST_TEST;
      drect_pkg::ST_TEST: begin
        if (status.hit || status.last) begin
          state_next = drect_pkg::ST_DONE;
        end else begin
          state_next = drect_pkg::ST_FETCH;
        end
      end
      drect_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          state_next = drect_pkg::ST_IDLE;
        end
      end
      default: state_next = drect_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready         = (state == drect_pkg::ST_IDLE);
    cmd              = '0;
    cmd.take_record  = take && (command == drect_pkg::CMD_RECORD);
    cmd.take_clear   = take && (command == drect_pkg::CMD_CLEAR);
    cmd.take_pixel   = take && (command == drect_pkg::CMD_PIXEL);
    cmd.test         = (state == drect_pkg::ST_TEST);
    cmd.advance      = (state == drect_pkg::ST_TEST) && !status.hit && !status.last;
    cmd.load_out     = (state == drect_pkg::ST_DONE) && !status.out_busy;
  end

endmodule

### rtl/drect_datapath.sv
// Datapath: config registers, rectangle table, border test and output register.
`timescale 1ns / 1ps
module drect_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic signed [15:0]   rect_x,
  input  logic signed [15:0]   rect_y,
  input  logic signed [15:0]   rect_width,
  input  logic signed [15:0]   rect_height,
  input  logic [14:0]          pixel_x,
  input  logic [14:0]          pixel_y,
  input  logic [15:0]          pixel_value,
  input  drect_pkg::dp_cmd_t    cmd,
  output drect_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          pixel_out,
  output logic                 on_outline,
  output logic                 table_full
);

  logic                              overlay_enable;
  logic [15:0]                       outline_color;
  drect_pkg::rect_t                  rect_table [drect_pkg::MAX_RECTS];
  drect_pkg::rect_t                  rdata;
  logic [drect_pkg::RECT_CNT_W-1:0]  rect_count;
  logic [drect_pkg::RECT_CNT_W-1:0]  idx;
  logic [14:0]                       px;
  logic [14:0]                       py;
  logic [15:0]                       pv;
  logic                              is_pixel;
  logic                              hit_flag;
  logic                              full_flag;
  logic                              can_store;
  logic                              hit;

  assign can_store = overlay_enable && (rect_count < drect_pkg::RECT_CNT_W'(drect_pkg::MAX_RECTS));
  assign hit       = drect_pkg::rect_border_hit(rdata, px, py);

  always_comb begin
    status             = '0;
    status.scan_needed = overlay_enable && (rect_count != '0);
    status.hit         = hit;
    status.last        = (idx + 1'b1) == rect_count;
    status.out_busy    = out_valid && !out_ready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_enable <= 1'b0;
      outline_color  <= drect_pkg::OUTLINE_COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        drect_pkg::CFG_ENABLE: overlay_enable <= cfg_data[0];
        drect_pkg::CFG_COLOR:  outline_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rectangle table: one write port, registered read at the scan index
  always_ff @(posedge clk) begin
    if (cmd.take_record && can_store) begin
      rect_table[rect_count[drect_pkg::RECT_IDX_W-1:0]] <=
        '{x: rect_x, y: rect_y, w: rect_width, h: rect_height};
    end
    rdata <= rect_table[idx[drect_pkg::RECT_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_count <= '0;
    end else if (cmd.take_clear) begin
      rect_count <= '0;
    end else if (cmd.take_record && can_store) begin
      rect_count <= rect_count + 1'b1;
    end
  end

  // Item working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.take_pixel) begin
      idx <= '0;
    end else if (cmd.advance) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      px        <= pixel_x;
      py        <= pixel_y;
      pv        <= pixel_value;
      is_pixel  <= 1'b1;
      hit_flag  <= 1'b0;
      full_flag <= 1'b0;
    end else if (cmd.take_record) begin
      is_pixel  <= 1'b0;
      hit_flag  <= 1'b0;
      full_flag <= overlay_enable && !can_store;
    end else if (cmd.test && hit) begin
      hit_flag  <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (!is_pixel) begin
        pixel_out <= 16'h0000;
      end else if (hit_flag) begin
        pixel_out <= {outline_color[7:0], outline_color[15:8]};
      end else begin
        pixel_out <= pv;
      end
      on_outline <= is_pixel && hit_flag;
      table_full <= !is_pixel && full_flag;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rect_count <= drect_pkg::RECT_CNT_W'(drect_pkg::MAX_RECTS))
    else $error("rectangle count above table depth");

  a_test_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.test |-> (idx < rect_count))
    else $error("border test on an entry beyond the table fill");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("output register loaded while a result is still held");

  a_record_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_record && can_store) |=> (rect_count == $past(rect_count) + 1'b1))
    else $error("stored rectangle not counted");

endmodule

### test/dirty_rect_outline_overlay_tb.sv
// Self-checking testbench for the rectangle outline overlay.
`timescale 1ns / 1ps
module dirty_rect_outline_overlay_tb;

  // Command value the block must ignore: no result, no state change
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Settle past the longest result, a scan of the whole table
  localparam int SETTLE_CYCLES   = 2 * drect_pkg::MAX_RECTS + 8;
  localparam int CHOKE_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PHASE_ITEMS     = 155;
  localparam int NUM_PHASES      = 7;
  localparam int FIRST_ENABLED_ROW = 4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [14:0]        px;
    logic [14:0]        py;
    logic [15:0]        pv;
  } overlay_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        on_outline;
    logic        table_full;
  } overlay_result_t;

  // One row of the directed table; pinned rows carry a hand-written result
  typedef struct packed {
    overlay_item_t   it;
    logic            pinned;
    overlay_result_t res;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          command;
  logic signed [15:0]  rect_x;
  logic signed [15:0]  rect_y;
  logic signed [15:0]  rect_width;
  logic signed [15:0]  rect_height;
  logic [14:0]         pixel_x;
  logic [14:0]         pixel_y;
  logic [15:0]         pixel_value;
  logic                out_valid;
  logic                out_ready;
  logic [15:0]         pixel_out;
  logic                on_outline;
  logic                table_full;

  dirty_rect_outline_overlay u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_out   (pixel_out),
    .on_outline  (on_outline),
    .table_full  (table_full)
  );

  // Shadow copy of the block: recorded rectangles, their count and the registers
  int          shadow_x [drect_pkg::MAX_RECTS];
  int          shadow_y [drect_pkg::MAX_RECTS];
  int          shadow_w [drect_pkg::MAX_RECTS];
  int          shadow_h [drect_pkg::MAX_RECTS];
  int          shadow_count;
  logic        shadow_enable;
  logic [15:0] shadow_color;

  overlay_result_t overlay_results_due[$];
  stim_row_t       directed_rows[$];

  // Side information for the transaction currently offered on the input
  logic            drv_pinned;
  overlay_result_t drv_pin_res;

  int   mismatches;
  int   stall_cycles;
  int   phase_items;
  logic in_calm;
  logic choke_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out what one accepted transaction produces, and advance the shadow table
  function automatic void predict_overlay(input overlay_item_t it, output logic has_result,
                                          output overlay_result_t res);
    int   px;
    int   py;
    int   right;
    int   bottom;
    logic hit;
    has_result = 1'b0;
    res        = '0;
    hit        = 1'b0;
    case (it.cmd)
      drect_pkg::CMD_RECORD: begin
        has_result = 1'b1;
        if (shadow_enable) begin
          if (shadow_count < drect_pkg::MAX_RECTS) begin
            shadow_x[shadow_count] = int'(it.x);
            shadow_y[shadow_count] = int'(it.y);
            shadow_w[shadow_count] = int'(it.w);
            shadow_h[shadow_count] = int'(it.h);
            shadow_count++;
          end else begin
            res.table_full = 1'b1;
          end
        end
      end
      drect_pkg::CMD_CLEAR: begin
        shadow_count = 0;
      end
      drect_pkg::CMD_PIXEL: begin
        has_result = 1'b1;
        px = int'(it.px);
        py = int'(it.py);
        if (shadow_enable) begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_w[i] > 0 && shadow_h[i] > 0) begin
              // Full-width sums: no wrap even near the top of the coordinate range
              right  = shadow_x[i] + shadow_w[i] - 1;
              bottom = shadow_y[i] + shadow_h[i] - 1;
              if (px >= shadow_x[i] && px <= right && py >= shadow_y[i] && py <= bottom &&
                  (py == shadow_y[i] || py == bottom || px == shadow_x[i] || px == right))
                hit = 1'b1;
            end
          end
        end
        res.pixel_out  = hit ? {shadow_color[7:0], shadow_color[15:8]} : it.pv;
        res.on_outline = hit;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample both channels at the rising edge: predict on input transactions,
  // compare on output transactions against the oldest prediction
  always @(posedge clk) begin
    overlay_item_t   seen;
    overlay_result_t want;
    logic            has_result;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen = '{command, rect_x, rect_y, rect_width, rect_height,
                 pixel_x, pixel_y, pixel_value};
        predict_overlay(seen, has_result, want);
        if (has_result)
          overlay_results_due.push_back(drv_pinned ? drv_pin_res : want);
      end
      if (out_valid && out_ready) begin
        if (overlay_results_due.size() == 0) begin
          report_mismatch("unexpected result, pixel_out", int'(pixel_out), 0);
        end else begin
          want = overlay_results_due.pop_front();
          if (pixel_out !== want.pixel_out)
            report_mismatch("pixel_out", int'(pixel_out), int'(want.pixel_out));
          if (on_outline !== want.on_outline)
            report_mismatch("on_outline", int'(on_outline), int'(want.on_outline));
          if (table_full !== want.table_full)
            report_mismatch("table_full", int'(table_full), int'(want.table_full));
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random holds on out_ready, calm stretches, and one long choke
  // on request so the block backs up and stalls its input
  initial begin
    int   hold_left;
    int   mode_left;
    logic calm;
    logic rdy;
    out_ready = 1'b0;
    hold_left = 0;
    mode_left = 0;
    calm      = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (choke_req) begin
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
        choke_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 200);
        end
        mode_left--;
        if (hold_left > 0) begin
          rdy = 1'b0;
          hold_left--;
        end else begin
          rdy = 1'b1;
          if (!calm && $urandom_range(0, 2) == 0) hold_left = pick_gap();
        end
        out_ready <= rdy;
      end
    end
  end

  // Offer one transaction after a random gap and hold it until accepted.
  // With no gap, valid stays high straight into the next transaction.
  task automatic drive_item(input overlay_item_t it, input logic pinned,
                            input overlay_result_t pin_res);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command     <= it.cmd;
    rect_x      <= it.x;
    rect_y      <= it.y;
    rect_width  <= it.w;
    rect_height <= it.h;
    pixel_x     <= it.px;
    pixel_y     <= it.py;
    pixel_value <= it.pv;
    in_valid    <= 1'b1;
    drv_pinned  = pinned;
    drv_pin_res = pin_res;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic issue(input overlay_item_t it);
    drive_item(it, 1'b0, '0);
    if (it.cmd != CMD_UNUSED) phase_items++;
  endtask

  // Drop valid, wait for every predicted result, then let a clear or an
  // ignored command finish before anything touches the registers
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (overlay_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic en, input logic [15:0] color);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= drect_pkg::CFG_ENABLE;
    cfg_data  <= {15'd0, en};
    @(negedge clk);
    cfg_index <= drect_pkg::CFG_COLOR;
    cfg_data  <= color;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_enable = en;
    shadow_color  = color;
  endtask

  task automatic add_row(input logic [1:0] cmd, input int x, input int y, input int w,
                         input int h, input int px, input int py, input int pv,
                         input logic pinned, input int pix, input logic on, input logic full);
    stim_row_t row;
    row.it        = '{cmd, x[15:0], y[15:0], w[15:0], h[15:0], px[14:0], py[14:0], pv[15:0]};
    row.pinned    = pinned;
    row.res       = '{pix[15:0], on, full};
    directed_rows.push_back(row);
  endtask

  // Steer a pixel coordinate onto or next to one edge of a rectangle, or inside it
  function automatic int border_offset(input int size);
    case ($urandom_range(0, 6))
      0: return -1;
      1: return 0;
      2: return 1;
      3: return size - 2;
      4: return size - 1;
      5: return size;
      default: return $urandom_range(0, (size > 0) ? size : 0);
    endcase
  endfunction

  function automatic overlay_item_t random_rect();
    overlay_item_t it;
    int            org;
    it     = '0;
    it.cmd = drect_pkg::CMD_RECORD;
    if ($urandom_range(0, 9) == 0) begin
      it.x = 16'($urandom);
      it.y = 16'($urandom);
      it.w = 16'($urandom);
      it.h = 16'($urandom);
    end else begin
      // Cluster near the origin or near the top of the coordinate range
      org  = ($urandom_range(0, 3) == 0) ? 32560 : 0;
      it.x = 16'(org + $urandom_range(0, 200) - 20);
      org  = ($urandom_range(0, 3) == 0) ? 32560 : 0;
      it.y = 16'(org + $urandom_range(0, 200) - 20);
      it.w = 16'($urandom_range(0, 14) - 2);
      it.h = 16'($urandom_range(0, 14) - 2);
    end
    return it;
  endfunction

  // Random part: mostly clear/record/pixel sequences whose pixels land on or
  // beside recorded borders, the rest fully random transactions
  task automatic run_phase(input int quota);
    overlay_item_t recs[$];
    overlay_item_t it;
    int            n;
    int            k;
    int            px;
    int            py;
    phase_items = 0;
    while (phase_items < quota) begin
      in_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 1) == 1) begin
          it     = '0;
          it.cmd = drect_pkg::CMD_CLEAR;
          it.pv  = 16'($urandom);
          issue(it);
          recs.delete();
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
        repeat (n) begin
          it = random_rect();
          it.px = 15'($urandom);
          it.py = 15'($urandom);
          it.pv = 16'($urandom);
          issue(it);
          recs.push_back(it);
        end
        n = $urandom_range(3, 12);
        repeat (n) begin
          it     = '0;
          it.cmd = drect_pkg::CMD_PIXEL;
          it.x   = 16'($urandom);
          it.pv  = 16'($urandom);
          k      = $urandom_range(0, recs.size() - 1);
          px     = int'(recs[k].x) + border_offset(int'(recs[k].w));
          py     = int'(recs[k].y) + border_offset(int'(recs[k].h));
          if (px < 0 || px > 32767) px = $urandom_range(0, 32767);
          if (py < 0 || py > 32767) py = $urandom_range(0, 32767);
          it.px  = 15'(px);
          it.py  = 15'(py);
          issue(it);
        end
      end else begin
        it     = '0;
        it.cmd = 2'($urandom_range(0, 3));
        it.x   = 16'($urandom);
        it.y   = 16'($urandom);
        it.w   = 16'($urandom);
        it.h   = 16'($urandom);
        it.px  = 15'($urandom);
        it.py  = 15'($urandom);
        it.pv  = 16'($urandom);
        issue(it);
      end
    end
  endtask

  initial begin
    logic        phase_en   [NUM_PHASES];
    logic [15:0] phase_color[NUM_PHASES];
    // Known values on every input from time zero
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = drect_pkg::CFG_ENABLE;
    cfg_data    = 16'd0;
    in_valid    = 1'b0;
    command     = drect_pkg::CMD_PIXEL;
    rect_x      = '0;
    rect_y      = '0;
    rect_width  = '0;
    rect_height = '0;
    pixel_x     = '0;
    pixel_y     = '0;
    pixel_value = '0;
    drv_pinned  = 1'b0;
    drv_pin_res = '0;
    mismatches  = 0;
    stall_cycles = 0;
    in_calm     = 1'b0;
    choke_req   = 1'b0;
    shadow_count  = 0;
    shadow_enable = 1'b0;
    shadow_color  = drect_pkg::OUTLINE_COLOR_RESET;

    // Directed rows. Overlay is still off for the first few.
    //      cmd                    x       y       w      h      px     py     pv
    //      pin out      on full
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     0,     0,     'h1234,
            1, 'h1234, 0, 0);
    add_row(drect_pkg::CMD_RECORD, 0,      0,      1,     1,     0,     0,     0,
            1, 0,      0, 0);
    add_row(CMD_UNUSED,            0,      0,      0,     0,     0,     0,     0,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     0,     0,     'h5555,
            1, 'h5555, 0, 0);
    // Overlay on, default outline color from here on
    add_row(drect_pkg::CMD_RECORD, 0,      0,      1,     1,     0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     0,     0,     'hABCD,
            1, 'h1FF8, 1, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     1,     0,     'h00FF,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_RECORD, -32768, -32768, 32767, 32767, 0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_RECORD, 32767,  32767,  1,     1,     0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     32767, 32767, 'hFFFF,
            1, 'h1FF8, 1, 0);
    // Empty rectangles: zero width, negative width
    add_row(drect_pkg::CMD_RECORD, 100,    100,    0,     5,     0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_RECORD, 200,    200,    -1,    5,     0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     100,   100,   'h0001,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     200,   200,   'h0002,
            0, 0,      0, 0);
    // Each border of one rectangle, its interior, and just outside
    add_row(drect_pkg::CMD_RECORD, 10,     20,     5,     4,     0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     10,    22,    'h1111,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     14,    22,    'h2222,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     12,    20,    'h3333,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     12,    23,    'h4444,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     12,    22,    'h5555,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     15,    22,    'h6666,
            0, 0,      0, 0);
    // Overlap: interior of the first, left border of the second
    add_row(drect_pkg::CMD_RECORD, 12,     18,     10,    10,    0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     12,    22,    'h7777,
            0, 0,      0, 0);
    // Right edge far past the 16-bit range: sums must not wrap
    add_row(drect_pkg::CMD_RECORD, 32000,  32000,  32767, 32767, 0,     0,     0,
            1, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     32767, 32000, 'h8888,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_CLEAR,  0,      0,      0,     0,     0,     0,     0,
            0, 0,      0, 0);
    add_row(drect_pkg::CMD_PIXEL,  0,      0,      0,     0,     10,    22,    'h9999,
            0, 0,      0, 0);

    phase_en[0] = 1'b1;  phase_color[0] = 16'h0000;
    phase_en[1] = 1'b1;  phase_color[1] = 16'hFFFF;
    phase_en[2] = 1'b0;  phase_color[2] = 16'($urandom);
    phase_en[3] = 1'b1;  phase_color[3] = 16'($urandom);
    phase_en[4] = 1'b1;  phase_color[4] = 16'($urandom);
    phase_en[5] = 1'b0;  phase_color[5] = drect_pkg::OUTLINE_COLOR_RESET;
    phase_en[6] = 1'b1;  phase_color[6] = 16'($urandom);

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (i == FIRST_ENABLED_ROW) begin
        drain_pipeline();
        apply_config(1'b1, drect_pkg::OUTLINE_COLOR_RESET);
      end
      drive_item(directed_rows[i].it, directed_rows[i].pinned, directed_rows[i].res);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipeline();
      apply_config(phase_en[p], phase_color[p]);
      // Choke the output early in one phase while the input keeps offering
      if (p == 1) choke_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    drain_pipeline();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### dirty_rect_outline_overlay.f
rtl/drect_pkg.sv
rtl/drect_ctrl.sv
rtl/drect_datapath.sv
rtl/dirty_rect_outline_overlay.sv
test/dirty_rect_outline_overlay_tb.sv
